// ===== rtl/core/kslpd_pkg.sv =====
package kslpd_pkg;

    localparam int unsigned KeyCodeW  = 10;
    localparam int unsigned EvTypeW   = 5;
    localparam int unsigned EvValueW  = 2;
    localparam int unsigned CountW    = 16;
    localparam int unsigned CfgIndexW = 2;
    localparam int unsigned CfgDataW  = 16;
    localparam int unsigned InDataW   = 24;  // 17 bits of fields, padded to whole bytes
    localparam int unsigned OutDataW  = 16;

    localparam logic [EvTypeW-1:0]   EvTypeKey    = 5'd1;
    localparam logic [EvValueW-1:0]  EvValRelease = 2'd0;
    localparam logic [EvValueW-1:0]  EvValPress   = 2'd1;
    localparam logic [CountW-1:0]    CountMax     = 16'hFFFF;
    localparam logic [CountW-1:0]    SinceReset   = 16'd10000;
    localparam logic [KeyCodeW-1:0]  WatchedKeyRst = 10'd0;
    localparam logic [CountW-1:0]    LongThrRst   = 16'd1000;
    localparam logic [CountW-1:0]    LockoutRst   = 16'd200;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_WATCHED_KEY = 2'd0,
        CFG_LONG_THR    = 2'd1,
        CFG_LOCKOUT     = 2'd2
    } cfg_index_t;

    typedef enum logic {
        ACT_TICK  = 1'b0,
        ACT_EVENT = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        OUT_NONE       = 2'd0,
        OUT_SHORT      = 2'd1,
        OUT_LONG       = 2'd2,
        OUT_SUPPRESSED = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [KeyCodeW-1:0] watched_key;
        logic [CountW-1:0]   long_threshold_ms;
        logic [CountW-1:0]   lockout_ms;
    } cfg_t;

    typedef struct packed {
        action_t             action;
        logic [EvTypeW-1:0]  event_type;
        logic [KeyCodeW-1:0] event_code;
        logic [EvValueW-1:0] event_value;
    } item_t;

    typedef struct packed {
        outcome_t          outcome;
        logic [CountW-1:0] held_time;
    } result_t;

    function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
        return (v == CountMax) ? CountMax : v + CountW'(1);
    endfunction

endpackage

// ===== rtl/core/kslpd_cfg.sv =====
module kslpd_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [kslpd_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [kslpd_pkg::CfgDataW-1:0]  cfg_wdata,
    output kslpd_pkg::cfg_t                 cfg
);
    import kslpd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.watched_key       <= WatchedKeyRst;
            cfg_reg.long_threshold_ms <= LongThrRst;
            cfg_reg.lockout_ms        <= LockoutRst;
        end else if (cfg_wr_en) begin
            // index beyond the list: write dropped
            unique case (cfg_index)
                CFG_WATCHED_KEY: cfg_reg.watched_key       <= cfg_wdata[KeyCodeW-1:0];
                CFG_LONG_THR:    cfg_reg.long_threshold_ms <= cfg_wdata;
                CFG_LOCKOUT:     cfg_reg.lockout_ms        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/kslpd_eval.sv =====
module kslpd_eval (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  kslpd_pkg::item_t   item,
    input  kslpd_pkg::cfg_t    cfg,
    output kslpd_pkg::result_t result
);
    import kslpd_pkg::*;

    logic              key_down_reg,  key_down_next;
    logic              long_done_reg, long_done_next;
    logic [CountW-1:0] hold_reg,      hold_next;
    logic [CountW-1:0] since_reg,     since_next;

    logic [CountW-1:0] hold_inc;
    logic [CountW-1:0] since_inc;
    logic              is_watched;
    logic              lockout_over;

    assign hold_inc     = sat_inc(hold_reg);
    assign since_inc    = sat_inc(since_reg);
    assign is_watched   = (item.event_type == EvTypeKey) && (item.event_code == cfg.watched_key);
    assign lockout_over = (since_reg >= cfg.lockout_ms);

    always_comb begin
        key_down_next    = key_down_reg;
        long_done_next   = long_done_reg;
        hold_next        = hold_reg;
        since_next       = since_reg;
        result.outcome   = OUT_NONE;
        result.held_time = '0;
        if (item.action == ACT_TICK) begin
            since_next = since_inc;
            if (key_down_reg) begin
                hold_next = hold_inc;
                if (!long_done_reg && hold_inc >= cfg.long_threshold_ms &&
                    since_inc >= cfg.lockout_ms) begin
                    long_done_next   = 1'b1;
                    since_next       = '0;
                    result.outcome   = OUT_LONG;
                    result.held_time = hold_inc;
                end
            end
        end else if (is_watched) begin
            if (item.event_value == EvValPress && !key_down_reg) begin
                key_down_next  = 1'b1;
                long_done_next = 1'b0;
                hold_next      = '0;
            end else if (item.event_value == EvValRelease && key_down_reg) begin
                if (!long_done_reg) begin
                    result.held_time = hold_reg;
                    if (lockout_over) begin
                        result.outcome = OUT_SHORT;
                        since_next     = '0;
                    end else begin
                        result.outcome = OUT_SUPPRESSED;
                    end
                end
                key_down_next  = 1'b0;
                long_done_next = 1'b0;
                hold_next      = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_down_reg  <= 1'b0;
            long_done_reg <= 1'b0;
            hold_reg      <= '0;
            since_reg     <= SinceReset;
        end else if (step) begin
            key_down_reg  <= key_down_next;
            long_done_reg <= long_done_next;
            hold_reg      <= hold_next;
            since_reg     <= since_next;
        end
    end

endmodule

// ===== rtl/core/key_short_long_press_detector.sv =====
// Classifies presses of one configured key as short or long from a stream of
// 1 ms ticks and key events. Every transaction in gives exactly one
// transaction out. An item is taken every clock while the input does not
// stall: it is captured in an input register, evaluated against the press
// state in the next cycle and placed in the output register at an edge where
// that register is empty or being read. The input stalls only when both
// registers hold items and the output transaction is not being taken.
// Configuration is written through the cfg port. The user must write it
// only while no item is in flight; the block itself does not enforce this.
module key_short_long_press_detector (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [4:0] event_type, [14:5] event_code, [16:15] event_value, [23:17] zero
    input  logic [kslpd_pkg::InDataW-1:0]   s_tdata,
    // [0] action
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] held_time
    output logic [kslpd_pkg::OutDataW-1:0]  m_tdata,
    // [1:0] outcome
    output logic [1:0]                      m_tuser,
    input  logic                            cfg_wr_en,
    input  logic [kslpd_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [kslpd_pkg::CfgDataW-1:0]  cfg_wdata
);
    import kslpd_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_vld_reg;
    result_t res;
    result_t out_res_reg;
    logic    out_vld_reg;
    logic    advance;
    logic    s_take;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    kslpd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    kslpd_eval u_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_take) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg.action      <= action_t'(s_tuser);
            in_item_reg.event_type  <= s_tdata[4:0];
            in_item_reg.event_code  <= s_tdata[14:5];
            in_item_reg.event_value <= s_tdata[16:15];
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_res_reg.held_time;
    assign m_tuser  = out_res_reg.outcome;

    // nothing to report carries a zero hold time
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == OUT_NONE) |-> (m_tdata == '0))
        else $error("outcome none with non-zero held_time");

    // input side only stalls behind a full, blocked output register
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("pipeline not empty after reset");

endmodule
